// ----- sv/xdkc_pkg.sv -----
// Shared types and constants for the XOR-distance k-closest selector.
package xdkc_pkg;

    localparam int HIGH_W  = 32;
    localparam int MID_W   = 64;
    localparam int LOW_W   = 64;
    localparam int DIST_W  = HIGH_W + MID_W + LOW_W;
    localparam int LIMIT_W = 4;
    localparam int RANK_W  = 3;

    localparam int RESULT_MAX_DEF = 8;
    localparam int TAG_BITS_DEF   = 10;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_NODE  = 1'b1;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_SHIFT,
        OP_CLEAR
    } cell_op_t;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    // broadcast from the controller to every cell of the chain
    typedef struct packed {
        cell_op_t            op;
        logic [DIST_W-1:0]   cand_dist;
    } cell_ctrl_t;

endpackage

// ----- sv/xdkc_in_if.sv -----
// Input channel: start and candidate beats.
interface xdkc_in_if #(
    parameter int TAG_BITS = xdkc_pkg::TAG_BITS_DEF
);
    import xdkc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 command;
    logic [HIGH_W-1:0]    key_high;
    logic [MID_W-1:0]     key_mid;
    logic [LOW_W-1:0]     key_low;
    logic [TAG_BITS-1:0]  node_tag;
    logic [LIMIT_W-1:0]   result_limit;
    logic                 last_item;

    modport source (
        output valid, command, key_high, key_mid, key_low, node_tag, result_limit, last_item,
        input  ready
    );

    modport sink (
        input  valid, command, key_high, key_mid, key_low, node_tag, result_limit, last_item,
        output ready
    );

endinterface

// ----- sv/xdkc_out_if.sv -----
// Output channel: result beats, closest first.
interface xdkc_out_if #(
    parameter int TAG_BITS = xdkc_pkg::TAG_BITS_DEF
);
    import xdkc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [TAG_BITS-1:0]  result_tag;
    logic [RANK_W-1:0]    rank;
    logic                 empty_res;
    logic                 last_result;

    modport source (
        output valid, result_tag, rank, empty_res, last_result,
        input  ready
    );

    modport sink (
        input  valid, result_tag, rank, empty_res, last_result,
        output ready
    );

endinterface

// ----- sv/xdkc_cell.sv -----
// One slot of the sorted insertion chain: holds a distance, a tag and a valid bit.
module xdkc_cell #(
    parameter int TAG_BITS = xdkc_pkg::TAG_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  xdkc_pkg::cell_ctrl_t          ctrl,
    input  logic [TAG_BITS-1:0]           new_tag,
    input  logic                          prev_take,
    input  logic                          prev_valid,
    input  logic [xdkc_pkg::DIST_W-1:0]   prev_dist,
    input  logic [TAG_BITS-1:0]           prev_tag,
    input  logic                          next_valid,
    input  logic [xdkc_pkg::DIST_W-1:0]   next_dist,
    input  logic [TAG_BITS-1:0]           next_tag,
    output logic                          take,
    output logic                          valid,
    output logic [xdkc_pkg::DIST_W-1:0]   cur_dist,
    output logic [TAG_BITS-1:0]           tag
);
    import xdkc_pkg::*;

    logic                 valid_reg, valid_next;
    logic [DIST_W-1:0]    dist_reg, dist_next;
    logic [TAG_BITS-1:0]  tag_reg, tag_next;

    // strictly closer, so equal distances stay behind earlier arrivals
    assign take     = !valid_reg || (ctrl.cand_dist < dist_reg);
    assign valid    = valid_reg;
    assign cur_dist = dist_reg;
    assign tag      = tag_reg;

    always_comb
    begin
        valid_next = valid_reg;
        dist_next  = dist_reg;
        tag_next   = tag_reg;
        case (ctrl.op)
            OP_INSERT:
            begin
                if (take)
                begin
                    if (prev_take)
                    begin
                        valid_next = prev_valid;
                        dist_next  = prev_dist;
                        tag_next   = prev_tag;
                    end
                    else
                    begin
                        valid_next = 1'b1;
                        dist_next  = ctrl.cand_dist;
                        tag_next   = new_tag;
                    end
                end
            end
            OP_SHIFT:
            begin
                valid_next = next_valid;
                dist_next  = next_dist;
                tag_next   = next_tag;
            end
            OP_CLEAR:
            begin
                valid_next = 1'b0;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg <= dist_next;
        tag_reg  <= tag_next;
    end

endmodule

// ----- sv/xdkc_ctrl.sv -----
// Query controller: target, limit, fill count, emission sequencer and output register.
module xdkc_ctrl #(
    parameter int RESULT_MAX = xdkc_pkg::RESULT_MAX_DEF,
    parameter int TAG_BITS   = xdkc_pkg::TAG_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    xdkc_in_if.sink                query,
    xdkc_out_if.source             result,
    input  logic                   take_last,
    input  logic [TAG_BITS-1:0]    head_tag,
    output xdkc_pkg::cell_ctrl_t   cell_ctrl
);
    import xdkc_pkg::*;

    localparam int CNT_W = $clog2(RESULT_MAX + 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(RESULT_MAX);

    state_t               state_reg, state_next;
    logic [DIST_W-1:0]    target_reg, target_next;
    logic [CNT_W-1:0]     limit_reg, limit_next;
    logic [CNT_W-1:0]     fill_reg, fill_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic [RANK_W-1:0]    rank_reg, rank_next;
    logic                 out_valid_reg, out_valid_next;
    logic [TAG_BITS-1:0]  out_tag_reg, out_tag_next;
    logic [RANK_W-1:0]    out_rank_reg, out_rank_next;
    logic                 out_empty_reg, out_empty_next;
    logic                 out_last_reg, out_last_next;

    logic                 accept;
    logic                 out_free;
    logic [CNT_W-1:0]     limit_sat;
    logic [CNT_W-1:0]     fill_ins;
    logic [DIST_W-1:0]    key;

    assign query.ready = (state_reg == ST_IDLE);
    assign accept      = query.valid && query.ready;
    assign out_free    = !out_valid_reg || result.ready;
    assign key         = {query.key_high, query.key_mid, query.key_low};

    assign result.valid       = out_valid_reg;
    assign result.result_tag  = out_tag_reg;
    assign result.rank        = out_rank_reg;
    assign result.empty_res   = out_empty_reg;
    assign result.last_result = out_last_reg;

    always_comb
    begin
        if (int'(query.result_limit) > RESULT_MAX)
        begin
            limit_sat = FULL;
        end
        else
        begin
            limit_sat = CNT_W'(query.result_limit);
        end
        if (take_last && (fill_reg != FULL))
        begin
            fill_ins = fill_reg + CNT_W'(1);
        end
        else
        begin
            fill_ins = fill_reg;
        end
    end

    always_comb
    begin
        state_next          = state_reg;
        target_next         = target_reg;
        limit_next          = limit_reg;
        fill_next           = fill_reg;
        rem_next            = rem_reg;
        rank_next           = rank_reg;
        out_valid_next      = out_valid_reg && !result.ready;
        out_tag_next        = out_tag_reg;
        out_rank_next       = out_rank_reg;
        out_empty_next      = out_empty_reg;
        out_last_next       = out_last_reg;
        cell_ctrl.op        = OP_HOLD;
        cell_ctrl.cand_dist = key ^ target_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (query.command == CMD_START)
                    begin
                        target_next  = key;
                        limit_next   = limit_sat;
                        fill_next    = '0;
                        cell_ctrl.op = OP_CLEAR;
                        if (query.last_item)
                        begin
                            rem_next   = '0;
                            state_next = ST_EMIT;
                        end
                    end
                    else
                    begin
                        cell_ctrl.op = OP_INSERT;
                        fill_next    = fill_ins;
                        if (query.last_item)
                        begin
                            rem_next   = (fill_ins < limit_reg) ? fill_ins : limit_reg;
                            state_next = ST_EMIT;
                        end
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (rem_reg == '0)
                    begin
                        out_tag_next   = '0;
                        out_rank_next  = '0;
                        out_empty_next = 1'b1;
                        out_last_next  = 1'b1;
                        cell_ctrl.op   = OP_CLEAR;
                        fill_next      = '0;
                        rank_next      = '0;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        out_tag_next   = head_tag;
                        out_rank_next  = rank_reg;
                        out_empty_next = 1'b0;
                        out_last_next  = (rem_reg == CNT_W'(1));
                        rem_next       = rem_reg - CNT_W'(1);
                        if (rem_reg == CNT_W'(1))
                        begin
                            // final result taken from the head; drop whatever is left
                            cell_ctrl.op = OP_CLEAR;
                            fill_next    = '0;
                            rank_next    = '0;
                            state_next   = ST_IDLE;
                        end
                        else
                        begin
                            cell_ctrl.op = OP_SHIFT;
                            rank_next    = rank_reg + RANK_W'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            target_reg    <= '0;
            limit_reg     <= '0;
            fill_reg      <= '0;
            rem_reg       <= '0;
            rank_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            target_reg    <= target_next;
            limit_reg     <= limit_next;
            fill_reg      <= fill_next;
            rem_reg       <= rem_next;
            rank_reg      <= rank_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_tag_reg   <= out_tag_next;
        out_rank_reg  <= out_rank_next;
        out_empty_reg <= out_empty_next;
        out_last_reg  <= out_last_next;
    end

endmodule

// ----- sv/xor_distance_k_closest_top.sv -----
// Top level of the XOR-distance k-closest selector: controller plus insertion chain.
// Throughput: one candidate beat per cycle while idle; each is inserted in the cycle it
//   is accepted. Emission: the final beat puts the controller in its emit state, and the
//   results then leave one per cycle through the single output register, which shifts
//   the chain head out, unless the output stalls; input is held off while the min(limit,
//   nodes kept) results, or one empty result if there are none, are emitted.
// Reset: asynchronous, active low; all cells invalid, target and limit zero, no clearing pass.
module xor_distance_k_closest_top #(
    parameter int RESULT_MAX = xdkc_pkg::RESULT_MAX_DEF,
    parameter int TAG_BITS   = xdkc_pkg::TAG_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    xdkc_in_if.sink       query,
    xdkc_out_if.source    result
);
    import xdkc_pkg::*;

    // Chain state, one element per cell. Cell 0 holds the closest node; valid cells
    // always form an unbroken run starting at cell 0.
    logic [RESULT_MAX-1:0]  take_vec;
    logic [RESULT_MAX-1:0]  valid_vec;
    logic [DIST_W-1:0]      dist_arr [RESULT_MAX];
    logic [TAG_BITS-1:0]    tag_arr  [RESULT_MAX];

    // Op and candidate distance are broadcast to every cell in the same cycle.
    cell_ctrl_t             cell_ctrl;

    xdkc_ctrl #(
        .RESULT_MAX (RESULT_MAX),
        .TAG_BITS   (TAG_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .query     (query),
        .result    (result),
        .take_last (take_vec[RESULT_MAX-1]),
        .head_tag  (tag_arr[0]),
        .cell_ctrl (cell_ctrl)
    );

    // Insertion: a cell "takes" when it is empty or the candidate is strictly closer.
    // Since the chain is sorted, take is monotonic along it: the first taking cell
    // loads the candidate, the ones after it load their left neighbor, and a
    // candidate that no cell takes is dropped. Emission shifts everything one cell
    // toward the head per result beat; the final beat clears the chain instead.
    for (genvar i = 0; i < RESULT_MAX; i++)
    begin : g_chain
        logic                 prev_take;
        logic                 prev_valid;
        logic [DIST_W-1:0]    prev_dist;
        logic [TAG_BITS-1:0]  prev_tag;
        logic                 next_valid;
        logic [DIST_W-1:0]    next_dist;
        logic [TAG_BITS-1:0]  next_tag;

        if (i == 0)
        begin : g_head
            assign prev_take  = 1'b0;
            assign prev_valid = 1'b0;
            assign prev_dist  = '0;
            assign prev_tag   = '0;
        end
        else
        begin : g_body
            assign prev_take  = take_vec[i-1];
            assign prev_valid = valid_vec[i-1];
            assign prev_dist  = dist_arr[i-1];
            assign prev_tag   = tag_arr[i-1];
        end

        if (i == RESULT_MAX - 1)
        begin : g_tail
            assign next_valid = 1'b0;
            assign next_dist  = '0;
            assign next_tag   = '0;
        end
        else
        begin : g_inner
            assign next_valid = valid_vec[i+1];
            assign next_dist  = dist_arr[i+1];
            assign next_tag   = tag_arr[i+1];
        end

        xdkc_cell #(
            .TAG_BITS (TAG_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (cell_ctrl),
            .new_tag    (query.node_tag),
            .prev_take  (prev_take),
            .prev_valid (prev_valid),
            .prev_dist  (prev_dist),
            .prev_tag   (prev_tag),
            .next_valid (next_valid),
            .next_dist  (next_dist),
            .next_tag   (next_tag),
            .take       (take_vec[i]),
            .valid      (valid_vec[i]),
            .cur_dist   (dist_arr[i]),
            .tag        (tag_arr[i])
        );
    end

    // Valid cells form a prefix starting at the head.
    a_valid_prefix: assert property (
        @(posedge clk) disable iff (!rst_n)
        ((valid_vec & (valid_vec + RESULT_MAX'(1))) == '0)
    ) else $error("cell chain has a hole");

    // A final beat starts emission, so input must be held off the next cycle.
    a_hold_after_last: assert property (
        @(posedge clk) disable iff (!rst_n)
        (query.valid && query.ready && query.last_item) |=> !query.ready
    ) else $error("input accepted during emission");

    // An empty result always closes its query.
    a_empty_is_last: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result.valid && result.empty_res) |-> result.last_result
    ) else $error("empty result not marked last");

endmodule
